>>> rtl/tftp_transfer_engine_top_assert.svh
// Assertion helpers for the RTL, used by tte_core; clock aclk, reset aresetn.
`ifndef TFTP_TRANSFER_ENGINE_TOP_ASSERT_SVH
`define TFTP_TRANSFER_ENGINE_TOP_ASSERT_SVH

// Consequence holds in the same cycle as the antecedent.
`define TTE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Consequence holds in the cycle after the antecedent.
`define TTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/tte_pkg.sv
package tte_pkg;

    localparam int OFFSET_BITS   = 24;
    localparam int SEGMENT_BYTES = 512;
    localparam int TALLY_W       = OFFSET_BITS + 1;
    localparam int COUNT_W       = 10;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [15:0] WELL_KNOWN_PORT = 16'd69;

    localparam logic [1:0] FUNC_START   = 2'd0;
    localparam logic [1:0] FUNC_PACKET  = 2'd1;
    localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

    localparam logic [15:0] OP_DATA  = 16'd3;
    localparam logic [15:0] OP_ACK   = 16'd4;
    localparam logic [15:0] OP_ERROR = 16'd5;

    localparam logic [2:0] ST_PROGRESS  = 3'd0;
    localparam logic [2:0] ST_DONE      = 3'd1;
    localparam logic [2:0] ST_TRUNCATED = 3'd2;
    localparam logic [2:0] ST_PEER_ERR  = 3'd3;
    localparam logic [2:0] ST_SYNC_FAIL = 3'd4;
    localparam logic [2:0] ST_BAD_OP    = 3'd5;

    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_RRQ  = 3'd1;
    localparam logic [2:0] KIND_WRQ  = 3'd2;
    localparam logic [2:0] KIND_DATA = 3'd3;
    localparam logic [2:0] KIND_ACK  = 3'd4;

    localparam logic [1:0] BOP_NONE  = 2'd0;
    localparam logic [1:0] BOP_STORE = 2'd1;
    localparam logic [1:0] BOP_LOAD  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTION   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_SIZE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_TRIES  = 2'd2;

    typedef struct packed {
        logic                   direction;
        logic [OFFSET_BITS-1:0] buffer_size;
        logic [7:0]             sync_tries;
    } tte_cfg_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [15:0]        opcode;
        logic [15:0]        block_field;
        logic [COUNT_W-1:0] payload_len;
        logic [15:0]        src_port;
        logic               from_peer;
    } tte_item_t;

    typedef struct packed {
        logic [2:0]             status;
        logic [2:0]             send_kind;
        logic [15:0]            send_block;
        logic [15:0]            dest_port;
        logic [1:0]             buffer_op;
        logic [OFFSET_BITS-1:0] buffer_offset;
        logic [COUNT_W-1:0]     byte_count;
        logic [15:0]            error_code;
        logic [OFFSET_BITS-1:0] file_total;
    } tte_result_t;

endpackage

>>> rtl/tftp_transfer_engine_top.sv
// TFTP client transfer sequencer, octet mode, get or put.
// Input stream (s_*): one event per transfer: start, packet header received,
// or receive timeout. Result stream (m_*): at most one result per event,
// saying what to send, which buffer range to store or load, and the status.
// Stray packets, packets and timeouts while idle, and unknown event codes give no result.
// Config port (cfg_*): index 0 direction, 1 buffer size, 2 sync tries;
// always ready, write only while no event is in flight.
// An accepted event passes the input register, then the result register, before it
// shows on m_*. Events are taken one per cycle while m_tready does not stall, set
// by the single state update between those two registers.
// The result register and the input register decouple the sides: a new event
// is taken while a finished result waits on m_tready. A stall on m_tready
// holds the result and, once the input register is also full, drops s_tready.
// Reset (aresetn low, synchronous) clears both stages, ends any transfer,
// sets the peer port to 69 and the config to get, size 0, five sync tries.
module tftp_transfer_engine_top
    import tte_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,  // opcode, block_field, payload_len, src_port
    input  logic [2:0]   s_tuser,  // func, from_peer
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, send_block, dest_port, buffer_op, buffer_offset, byte_count,
    // error_code, file_total
    output logic [111:0] m_tdata,
    output logic [2:0]   m_tuser,  // send_kind
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_data
);

    tte_cfg_t    cfg;
    tte_item_t   s_item;
    tte_result_t res;
    tte_result_t m_res;
    logic        res_valid;
    logic        out_free;

    assign s_item.func        = s_tuser[1:0];
    assign s_item.from_peer   = s_tuser[2];
    assign s_item.opcode      = s_tdata[15:0];
    assign s_item.block_field = s_tdata[31:16];
    assign s_item.payload_len = s_tdata[41:32];
    assign s_item.src_port    = s_tdata[57:42];

    assign m_tdata = {1'b0, m_res.file_total, m_res.error_code, m_res.byte_count,
                      m_res.buffer_offset, m_res.buffer_op, m_res.dest_port,
                      m_res.send_block, m_res.status};
    assign m_tuser = m_res.send_kind;

    tte_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tte_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_item    (s_item),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    tte_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (m_res)
    );

endmodule

>>> rtl/tte_cfg_regs.sv
module tte_cfg_regs
    import tte_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [OFFSET_BITS-1:0] cfg_data,
    output tte_cfg_t               cfg
);

    tte_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.direction   <= 1'b0;
            cfg_reg.buffer_size <= '0;
            cfg_reg.sync_tries  <= 8'd5;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DIRECTION:   cfg_reg.direction   <= cfg_data[0];
                CFG_BUFFER_SIZE: cfg_reg.buffer_size <= cfg_data;
                CFG_SYNC_TRIES:  cfg_reg.sync_tries  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/tte_core.sv
`include "tftp_transfer_engine_top_assert.svh"

module tte_core
    import tte_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  tte_cfg_t    cfg,
    input  logic        s_valid,
    output logic        s_ready,
    input  tte_item_t   s_item,
    input  logic        out_free,
    output logic        res_valid,
    output tte_result_t res
);

    localparam logic signed [TALLY_W-1:0] SEG_T = TALLY_W'(SEGMENT_BYTES);

    logic                          in_valid_reg, in_valid_next;
    tte_item_t                     in_item_reg;
    logic [15:0]                   next_block_reg, next_block_next;
    logic [7:0]                    sync_left_reg, sync_left_next;
    logic signed [TALLY_W-1:0]     byte_tally_reg, byte_tally_next;
    logic [OFFSET_BITS-1:0]        received_total_reg, received_total_next;
    logic [15:0]                   peer_port_reg, peer_port_next;
    logic                          active_reg, active_next;

    logic                          has_result;
    logic                          do_resync;
    logic                          advance;
    logic [7:0]                    sync_dec;
    logic [15:0]                   last_block;
    logic signed [TALLY_W-1:0]     bsize_s;
    logic signed [TALLY_W-1:0]     len_s;
    logic signed [TALLY_W:0]       room;
    logic signed [TALLY_W-1:0]     store_cnt;
    logic signed [TALLY_W-1:0]     tally_after;
    logic signed [TALLY_W-1:0]     resync_off;
    logic signed [TALLY_W-1:0]     resync_cnt;
    logic signed [TALLY_W-1:0]     ack_off;
    logic [OFFSET_BITS-1:0]        total_after;
    logic                          stray;
    tte_result_t                   r;

    assign bsize_s     = $signed({1'b0, cfg.buffer_size});
    assign len_s       = $signed({{(TALLY_W-COUNT_W){1'b0}}, in_item_reg.payload_len});
    // one bit wider: a tally left negative by a put can push room past the tally range
    assign room        = $signed({2'b00, cfg.buffer_size})
                       - $signed({byte_tally_reg[TALLY_W-1], byte_tally_reg});
    assign store_cnt   = (bsize_s > byte_tally_reg)
                       ? ((len_s < room) ? len_s : $signed(room[TALLY_W-1:0])) : '0;
    assign tally_after = byte_tally_reg + store_cnt;
    assign total_after = received_total_reg + OFFSET_BITS'(in_item_reg.payload_len);
    assign resync_off  = bsize_s - byte_tally_reg - SEG_T;
    assign resync_cnt  = (byte_tally_reg < 0) ? (byte_tally_reg + SEG_T) : SEG_T;
    assign ack_off     = bsize_s - byte_tally_reg;
    assign sync_dec    = sync_left_reg - 8'd1;
    assign last_block  = next_block_reg - 16'd1;
    assign stray       = !in_item_reg.from_peer
                      || (peer_port_reg != WELL_KNOWN_PORT
                          && in_item_reg.src_port != peer_port_reg);

    always_comb begin
        next_block_next     = next_block_reg;
        sync_left_next      = sync_left_reg;
        byte_tally_next     = byte_tally_reg;
        received_total_next = received_total_reg;
        peer_port_next      = peer_port_reg;
        active_next         = active_reg;
        has_result          = 1'b0;
        do_resync           = 1'b0;
        r                   = '0;

        unique case (in_item_reg.func)
            FUNC_START: begin
                has_result          = 1'b1;
                active_next         = 1'b1;
                sync_left_next      = cfg.sync_tries;
                received_total_next = '0;
                peer_port_next      = WELL_KNOWN_PORT;
                if (!cfg.direction) begin
                    next_block_next = 16'd1;
                    byte_tally_next = '0;
                    r.send_kind     = KIND_RRQ;
                end else begin
                    next_block_next = 16'd0;
                    byte_tally_next = bsize_s;
                    r.send_kind     = KIND_WRQ;
                end
            end
            FUNC_TIMEOUT: begin
                do_resync = active_reg;
            end
            FUNC_PACKET: begin
                if (active_reg && !stray) begin
                    has_result = 1'b1;
                    if (in_item_reg.opcode == OP_ERROR) begin
                        active_next  = 1'b0;
                        r.status     = ST_PEER_ERR;
                        r.error_code = in_item_reg.block_field;
                        if (bsize_s >= len_s) begin
                            byte_tally_next = len_s;
                            r.buffer_op     = BOP_STORE;
                            r.byte_count    = in_item_reg.payload_len;
                        end else begin
                            byte_tally_next = '0;
                        end
                    end else if (in_item_reg.opcode == OP_ACK && cfg.direction) begin
                        if (in_item_reg.block_field != next_block_reg) begin
                            do_resync = 1'b1;
                        end else begin
                            if (next_block_reg == 16'd0) begin
                                peer_port_next = in_item_reg.src_port;
                            end
                            sync_left_next = cfg.sync_tries;
                            if (byte_tally_reg < 0) begin
                                active_next = 1'b0;
                                r.status    = ST_DONE;
                            end else begin
                                byte_tally_next = byte_tally_reg - SEG_T;
                                next_block_next = next_block_reg + 16'd1;
                                r.send_kind     = KIND_DATA;
                                r.send_block    = next_block_reg + 16'd1;
                                r.buffer_op     = BOP_LOAD;
                                r.buffer_offset = ack_off[OFFSET_BITS-1:0];
                                r.byte_count    = (byte_tally_reg < SEG_T)
                                                ? byte_tally_reg[COUNT_W-1:0]
                                                : SEG_T[COUNT_W-1:0];
                            end
                        end
                    end else if (in_item_reg.opcode == OP_DATA && !cfg.direction) begin
                        if (in_item_reg.block_field != next_block_reg) begin
                            do_resync = 1'b1;
                        end else begin
                            if (next_block_reg == 16'd1) begin
                                peer_port_next = in_item_reg.src_port;
                            end
                            sync_left_next      = cfg.sync_tries;
                            received_total_next = total_after;
                            byte_tally_next     = tally_after;
                            next_block_next     = next_block_reg + 16'd1;
                            r.send_kind         = KIND_ACK;
                            r.send_block        = next_block_reg;
                            if (store_cnt > 0) begin
                                r.buffer_op     = BOP_STORE;
                                r.buffer_offset = byte_tally_reg[OFFSET_BITS-1:0];
                                r.byte_count    = store_cnt[COUNT_W-1:0];
                            end
                            if (len_s < SEG_T) begin
                                active_next = 1'b0;
                                r.status = ($signed({tally_after[TALLY_W-1], tally_after})
                                            < $signed({2'b00, total_after}))
                                         ? ST_TRUNCATED : ST_DONE;
                            end
                        end
                    end else begin
                        active_next = 1'b0;
                        r.status    = ST_BAD_OP;
                    end
                end
            end
            default: ;
        endcase

        if (do_resync) begin
            has_result     = 1'b1;
            sync_left_next = sync_dec;
            r              = '0;
            if (sync_dec == 8'd0) begin
                active_next = 1'b0;
                r.status    = ST_SYNC_FAIL;
            end else if (!cfg.direction) begin
                if (last_block == 16'd0) begin
                    r.send_kind = KIND_RRQ;
                end else begin
                    r.send_kind  = KIND_ACK;
                    r.send_block = last_block;
                end
            end else if (next_block_reg == 16'd0) begin
                r.send_kind = KIND_WRQ;
            end else begin
                r.send_kind     = KIND_DATA;
                r.send_block    = next_block_reg;
                r.buffer_op     = BOP_LOAD;
                r.buffer_offset = resync_off[OFFSET_BITS-1:0];
                r.byte_count    = resync_cnt[COUNT_W-1:0];
            end
        end

        r.dest_port  = peer_port_next;
        r.file_total = received_total_next;
    end

    assign advance   = in_valid_reg && (!has_result || out_free);
    assign s_ready   = !in_valid_reg || advance;
    assign res_valid = advance && has_result;
    assign res       = r;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            next_block_reg     <= '0;
            sync_left_reg      <= '0;
            byte_tally_reg     <= '0;
            received_total_reg <= '0;
            peer_port_reg      <= WELL_KNOWN_PORT;
            active_reg         <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (advance) begin
                next_block_reg     <= next_block_next;
                sync_left_reg      <= sync_left_next;
                byte_tally_reg     <= byte_tally_next;
                received_total_reg <= received_total_next;
                peer_port_reg      <= peer_port_next;
                active_reg         <= active_next;
            end
        end
    end

    `TTE_ASSERT_NEXT(a_final_status_ends, res_valid && res.status != ST_PROGRESS,
        !active_reg, "final status left transfer active")
    `TTE_ASSERT_SAME(a_load_only_for_data, res_valid && res.buffer_op == BOP_LOAD,
        res.send_kind == KIND_DATA, "buffer load without DATA send")
    `TTE_ASSERT_NEXT(a_held_item_stays, in_valid_reg && !advance,
        in_valid_reg && $stable(in_item_reg), "stalled item lost or changed")
    `TTE_ASSERT_SAME(a_stall_means_full, !s_ready, in_valid_reg,
        "input stalled with empty stage")

endmodule

>>> rtl/tte_out_stage.sv
module tte_out_stage
    import tte_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        res_valid,
    input  tte_result_t res,
    output logic        out_free,
    output logic        m_valid,
    input  logic        m_ready,
    output tte_result_t m_res
);

    logic        out_valid_reg, out_valid_next;
    tte_result_t out_res_reg;

    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_res    = out_res_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_valid) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_res_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
